### hdl/quadrature_encoder_speed_assert.svh
// Assertion macros shared by the quadrature encoder speed checker.
// No dependencies; the including file supplies clk and rst_n.
`ifndef QUADRATURE_ENCODER_SPEED_ASSERT_SVH
`define QUADRATURE_ENCODER_SPEED_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define QES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define QES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/qes_pkg.sv
// Shared types and constants for the quadrature encoder speed block.
// No dependencies.
package qes_pkg;

    localparam int PPR_W     = 16;  // pulses per revolution register
    localparam int CFG_IDX_W = 2;   // configuration index
    localparam int STEP_W    = 5;   // iteration counter, up to 32 steps
    localparam int Q_W       = 32;  // quotient bits, top bit flags saturation
    localparam int OUT_W     = 32;  // result field width
    localparam int FRAC_W    = 8;   // fraction bits of the speed

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_EDGE_A = 2'd1,
        FUNC_EDGE_B = 2'd2,
        FUNC_SYNC   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PPR       = 2'd0,
        REG_CLOCKWISE = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_D,
        S_MUL_N,
        S_DIV,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        logic start;  // sync transfer accepted
        logic take;   // result moves into the output register
    } eng_ctl_t;

    typedef struct packed {
        logic busy;   // engine holds a sync
        logic done;   // result ready
    } eng_sts_t;

endpackage

### hdl/qes_track.sv
// Event tracker: saturating timers, edge count, last interval, direction.
// Depends on qes_pkg.
module qes_track
    import qes_pkg::*;
#(
    parameter int CW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    func,
    input  logic          level_a,
    input  logic          level_b,
    output logic [CW-1:0] sync_time,
    output logic [CW-1:0] edge_cnt,
    output logic [CW-1:0] last_int,
    output logic          dir
);

    logic [CW-1:0] edge_timer_reg, edge_timer_next;
    logic [CW-1:0] sync_timer_reg, sync_timer_next;
    logic [CW-1:0] edge_count_reg, edge_count_next;
    logic [CW-1:0] last_int_reg, last_int_next;
    logic          dir_reg, dir_next;
    func_t         fn;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == '1) ? v : v + CW'(1);
    endfunction

    assign fn = func_t'(func);

    always_comb
    begin
        edge_timer_next = edge_timer_reg;
        sync_timer_next = sync_timer_reg;
        edge_count_next = edge_count_reg;
        last_int_next   = last_int_reg;
        dir_next        = dir_reg;
        if (accept)
        begin
            unique case (fn)
                FUNC_TICK:
                begin
                    edge_timer_next = sat_inc(edge_timer_reg);
                    sync_timer_next = sat_inc(sync_timer_reg);
                end
                FUNC_EDGE_A, FUNC_EDGE_B:
                begin
                    last_int_next   = edge_timer_reg;
                    edge_timer_next = '0;
                    edge_count_next = sat_inc(edge_count_reg);
                    // reverse when A levels differ, or B levels match
                    dir_next = (fn == FUNC_EDGE_A) ? (level_a != level_b)
                                                   : (level_a == level_b);
                end
                FUNC_SYNC:
                begin
                    sync_timer_next = '0;
                    edge_count_next = '0;
                end
                default:
                begin
                    edge_timer_next = edge_timer_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_timer_reg <= '0;
            sync_timer_reg <= '0;
            edge_count_reg <= '0;
            last_int_reg   <= '0;
            dir_reg        <= 1'b0;
        end
        else
        begin
            edge_timer_reg <= edge_timer_next;
            sync_timer_reg <= sync_timer_next;
            edge_count_reg <= edge_count_next;
            last_int_reg   <= last_int_next;
            dir_reg        <= dir_next;
        end
    end

    assign sync_time = sync_timer_reg;
    assign edge_cnt  = edge_count_reg;
    assign last_int  = last_int_reg;
    assign dir       = dir_reg;

endmodule

### hdl/qes_addsub.sv
// Shared wide adder/subtractor with carry out (carry set means a >= b on subtract).
// Depends on qes_pkg.
module qes_addsub
    import qes_pkg::*;
#(
    parameter int W = 97
)
(
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         carry
);

    assign {carry, sum} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);

endmodule

### hdl/qes_engine.sv
// Speed engine: shift-add multiplies and restoring division on one shared adder.
// Depends on qes_pkg and qes_addsub.
module qes_engine
    import qes_pkg::*;
#(
    parameter int CW  = 32,
    parameter int TPS = 1000000
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  eng_ctl_t                ctl,
    output eng_sts_t                sts,
    input  logic [PPR_W-1:0]        ppr,
    input  logic                    clockwise,
    input  logic [CW-1:0]           sync_time,
    input  logic [CW-1:0]           edge_cnt,
    input  logic [CW-1:0]           last_int,
    input  logic                    dir,
    output logic signed [OUT_W-1:0] speed,
    output logic [OUT_W-1:0]        edges_seen,
    output logic [OUT_W-1:0]        edge_interval
);

    localparam int TW       = $clog2(TPS + 1);
    localparam int NW       = CW + TW + FRAC_W;
    localparam int SW       = CW + PPR_W + 2 + Q_W - 1;
    localparam int AW       = (NW > SW) ? NW : SW;
    localparam int MW       = (TW > PPR_W) ? TW : PPR_W;
    localparam int DS_SHIFT = 2 + Q_W - 1;
    localparam int XW       = (CW > OUT_W) ? CW : OUT_W;

    eng_state_t         state_reg, state_next;
    logic [AW-1:0]      acc_reg, ds_reg;
    logic [MW-1:0]      mreg_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [Q_W-1:0]     q_reg;
    logic [CW-1:0]      cnt_reg, time_reg, int_reg;
    logic               use_cnt_reg, neg_reg;

    logic [AW-1:0]      add_a, add_b, sum;
    logic               sub, carry;
    logic               use_cnt, zero_case, last_step;
    logic [CW-1:0]      time_sel;
    logic [Q_W-1:0]     mag;
    logic [XW-1:0]      cnt_x, int_x;

    qes_addsub #(.W(AW)) u_addsub
    (
        .a     (add_a),
        .b     (add_b),
        .sub   (sub),
        .sum   (sum),
        .carry (carry)
    );

    assign use_cnt   = edge_cnt > last_int;
    assign time_sel  = use_cnt ? sync_time : last_int;
    assign zero_case = (edge_cnt < CW'(2)) || (ppr == '0) || (time_sel == '0);
    assign last_step = (step_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (ctl.start)
                    state_next = zero_case ? S_DONE : S_MUL_D;
            S_MUL_D:
                if (last_step)
                    state_next = use_cnt_reg ? S_MUL_N : S_DIV;
            S_MUL_N:
                if (last_step)
                    state_next = S_DIV;
            S_DIV:
                if (last_step)
                    state_next = S_DONE;
            S_DONE:
                if (ctl.take)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // adder steering and status
    always_comb
    begin
        sts.busy = (state_reg != S_IDLE);
        sts.done = (state_reg == S_DONE);
        add_a    = acc_reg << 1;
        add_b    = '0;
        sub      = 1'b0;
        unique case (state_reg)
            S_MUL_D:
                add_b = mreg_reg[MW-1] ? AW'(time_reg) : '0;
            S_MUL_N:
                add_b = mreg_reg[MW-1] ? AW'(cnt_reg) : '0;
            S_DIV:
            begin
                add_a = acc_reg;
                add_b = ds_reg;
                sub   = 1'b1;
            end
            default:
                add_b = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (ctl.start)
                begin
                    cnt_reg     <= edge_cnt;
                    time_reg    <= time_sel;
                    int_reg     <= last_int;
                    use_cnt_reg <= use_cnt;
                    neg_reg     <= dir ^ ~clockwise;
                    acc_reg     <= '0;
                    mreg_reg    <= MW'(ppr) << (MW - PPR_W);
                    step_reg    <= STEP_W'(PPR_W - 1);
                    q_reg       <= '0;
                end
            S_MUL_D:
            begin
                if (last_step)
                begin
                    // divisor 4*ppr*time, aligned to the top quotient bit
                    ds_reg   <= sum << DS_SHIFT;
                    acc_reg  <= use_cnt_reg ? '0 : (AW'(TPS) << FRAC_W);
                    mreg_reg <= MW'(TPS) << (MW - TW);
                    step_reg <= use_cnt_reg ? STEP_W'(TW - 1) : STEP_W'(Q_W - 1);
                end
                else
                begin
                    acc_reg  <= sum;
                    mreg_reg <= mreg_reg << 1;
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
            S_MUL_N:
            begin
                mreg_reg <= mreg_reg << 1;
                if (last_step)
                begin
                    acc_reg  <= sum << FRAC_W;
                    step_reg <= STEP_W'(Q_W - 1);
                end
                else
                begin
                    acc_reg  <= sum;
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
            S_DIV:
            begin
                if (carry)
                    acc_reg <= sum;
                q_reg    <= {q_reg[Q_W-2:0], carry};
                ds_reg   <= ds_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            default:
                q_reg <= q_reg;
        endcase
    end

    // top quotient bit set means the true quotient reached 2^31
    assign mag = q_reg[Q_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : q_reg;

    always_comb
    begin
        if (neg_reg)
            speed = OUT_W'(-mag);
        else if (q_reg[Q_W-1])
            speed = {1'b0, {(OUT_W-1){1'b1}}};
        else
            speed = OUT_W'(mag);
    end

    assign cnt_x = XW'(cnt_reg);
    assign int_x = XW'(int_reg);
    assign edges_seen    = (cnt_x > XW'({OUT_W{1'b1}})) ? '1 : cnt_x[OUT_W-1:0];
    assign edge_interval = (int_x > XW'({OUT_W{1'b1}})) ? '1 : int_x[OUT_W-1:0];

endmodule

### hdl/quadrature_encoder_speed.sv
// Top level of the x4 quadrature encoder speed measurement block.
// Depends on qes_pkg, qes_track, qes_engine (and qes_addsub below it).
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | func, level_a, level_b
//  out     | out_valid / out_stall  | speed, edges_seen, edge_interval
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Tick and edge events are accepted back to back while no sync is held.
// A sync whose speed is zero goes straight to the done state. Otherwise the
// shared adder runs the ppr multiply, on the count path the count multiply
// over T bits, T being the bit width of TICKS_PER_SECOND (20 at the default),
// and then the restoring division, one bit a cycle.
// in_stall stays high while the engine holds a sync, including a finished
// result waiting for the output register. Reset clears all timers, counts
// and out_valid but not the output payload; cfg_ready is always high.
module quadrature_encoder_speed
    import qes_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int COUNTER_WIDTH    = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // event input
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic                    level_a,
    input  logic                    level_b,
    // result output
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] speed,
    output logic [OUT_W-1:0]        edges_seen,
    output logic [OUT_W-1:0]        edge_interval,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [PPR_W-1:0]        cfg_data
);

    logic                    in_accept;
    logic [PPR_W-1:0]        ppr_reg, ppr_next;
    logic                    cw_reg, cw_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] speed_reg;
    logic [OUT_W-1:0]        edges_reg, interval_reg;

    logic [COUNTER_WIDTH-1:0] sync_time, edge_cnt, last_int;
    logic                     dir;
    eng_ctl_t                 eng_ctl;
    eng_sts_t                 eng_sts;
    logic signed [OUT_W-1:0]  eng_speed;
    logic [OUT_W-1:0]         eng_edges, eng_interval;

    // Hold off new events while the engine owns a sync.
    assign in_stall  = eng_sts.busy;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration decode; unknown indexes drop the transfer.
    always_comb
    begin
        ppr_next = ppr_reg;
        cw_next  = cw_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PPR:       ppr_next = cfg_data;
                REG_CLOCKWISE: cw_next  = cfg_data[0];
                default:       ppr_next = ppr_reg;
            endcase
        end
    end

    // Start the engine on an accepted sync; move its result when the output
    // register is empty or being drained this cycle.
    assign eng_ctl.start = in_accept && (func_t'(func) == FUNC_SYNC);
    assign eng_ctl.take  = eng_sts.done && (!out_valid_reg || !out_stall);

    assign out_valid_next = eng_ctl.take ? 1'b1 : (out_valid_reg && out_stall);

    qes_track #(.CW(COUNTER_WIDTH)) u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .func      (func),
        .level_a   (level_a),
        .level_b   (level_b),
        .sync_time (sync_time),
        .edge_cnt  (edge_cnt),
        .last_int  (last_int),
        .dir       (dir)
    );

    qes_engine #(.CW(COUNTER_WIDTH), .TPS(TICKS_PER_SECOND)) u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (eng_ctl),
        .sts           (eng_sts),
        .ppr           (ppr_reg),
        .clockwise     (cw_reg),
        .sync_time     (sync_time),
        .edge_cnt      (edge_cnt),
        .last_int      (last_int),
        .dir           (dir),
        .speed         (eng_speed),
        .edges_seen    (eng_edges),
        .edge_interval (eng_interval)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg       <= PPR_W'(1);
            cw_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ppr_reg       <= ppr_next;
            cw_reg        <= cw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload: load on take, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (eng_ctl.take)
        begin
            speed_reg    <= eng_speed;
            edges_reg    <= eng_edges;
            interval_reg <= eng_interval;
        end
    end

    assign out_valid     = out_valid_reg;
    assign speed         = speed_reg;
    assign edges_seen    = edges_reg;
    assign edge_interval = interval_reg;

endmodule

### hdl/qes_checker.sv
// Port-level checker for quadrature_encoder_speed, bound to the top level.
// Depends on qes_pkg and quadrature_encoder_speed_assert.svh.
`include "quadrature_encoder_speed_assert.svh"

module qes_checker
    import qes_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic [1:0]              func,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] speed,
    input logic [OUT_W-1:0]        edges_seen,
    input logic [OUT_W-1:0]        edge_interval
);

    `QES_ASSERT_NEXT(a_sync_busy, in_valid && !in_stall && func == FUNC_SYNC, in_stall, "sync accepted but block not busy")

    `QES_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && func != FUNC_SYNC, !$rose(out_valid), "result appeared without a sync")

    `QES_ASSERT_NOW(a_few_edges_zero, out_valid && edges_seen < 32'd2, speed == 0, "nonzero speed with fewer than two edges")

    `QES_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(speed) && $stable(edges_seen) && $stable(edge_interval), "stalled result changed")

endmodule

bind quadrature_encoder_speed qes_checker u_qes_checker (.*);
